>>> rtl/core/mqi_pkg.sv
package mqi_pkg;

    // request codes carried on s_axis_tuser
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_DROP   = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    // status codes carried on m_axis_tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // what the cell row does in a given cycle
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

endpackage

>>> rtl/core/middle_insert_queue.sv
// Ordered store of up to DEPTH signed words kept in a row of DEPTH cells, one
// word per cell, head in cell 0. Requests on s_axis: append at the tail, drop
// the head, insert at index floor((n+1)/2), remove index floor(n/2), where n
// is the count held. The cells from the addressed index on shift by one place
// in the cycle a request is accepted, so a new request can be taken every
// cycle while m_axis is not stalled. The result passes through stage A (cell
// row, removed word captured) and stage B (word collected from the cells).
// A full store rejects append/insert, an empty store rejects drop/remove;
// both leave the contents unchanged. Stored words are DATA_WIDTH bits,
// sign-extended or cut from the 32-bit value; the returned word is
// sign-extended or cut back to 32 bits. Count is reported modulo 128.
module middle_insert_queue #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] removed_value, [38:32] count, [39] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import mqi_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          r_occ;
    logic [CW-1:0]          n_occ;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_accept;
    logic                   w_a_adv;
    t_req                   w_req;
    logic                   w_is_put;
    logic                   w_reject;
    t_shift                 w_kind;
    logic [CW-1:0]          w_pos;
    t_status                w_status;
    logic signed [31:0]     w_in_value;
    logic [DATA_WIDTH-1:0]  w_store;
    logic [CW+6:0]          w_cnt_ext;

    logic [DATA_WIDTH-1:0]  w_data [DEPTH];
    logic [DATA_WIDTH-1:0]  w_tap  [DEPTH];
    logic [DATA_WIDTH-1:0]  w_taps_or;
    logic signed [DATA_WIDTH-1:0] w_word;

    // stage A: after the cell row update
    logic                   r_a_valid;
    t_status                r_a_status;
    logic [COUNT_W-1:0]     r_a_count;
    logic                   r_a_taken;
    // stage B: output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [COUNT_W-1:0]     r_out_count;
    logic [VALUE_W-1:0]     r_out_removed;

    assign w_a_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_a_valid || w_a_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_req      = t_req'(s_axis_tuser);
    assign w_is_put   = (w_req == REQ_APPEND) || (w_req == REQ_INSERT);
    assign w_full     = (r_occ == CW'(DEPTH));
    assign w_empty    = (r_occ == '0);
    assign w_reject   = w_is_put ? w_full : w_empty;
    assign w_in_value = s_axis_tdata;
    assign w_store    = DATA_WIDTH'(w_in_value);

    always_comb begin
        case (w_req)
            REQ_APPEND: w_pos = r_occ;
            REQ_DROP:   w_pos = '0;
            REQ_INSERT: w_pos = CW'((r_occ + 1'b1) >> 1);
            REQ_REMOVE: w_pos = r_occ >> 1;
            default:    w_pos = '0;
        endcase
    end

    always_comb begin
        if (!w_accept || w_reject) begin
            w_kind = SH_HOLD;
        end else if (w_is_put) begin
            w_kind = SH_INSERT;
        end else begin
            w_kind = SH_REMOVE;
        end
    end

    always_comb begin
        if (!w_reject) begin
            w_status = ST_DONE;
        end else if (w_is_put) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_EMPTY;
        end
    end

    always_comb begin
        case (w_kind)
            SH_INSERT: n_occ = r_occ + 1'b1;
            SH_REMOVE: n_occ = r_occ - 1'b1;
            default:   n_occ = r_occ;
        endcase
    end

    assign w_cnt_ext = (CW + 7)'(n_occ);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_data[gi];
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_data[gi];
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            mqi_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .PW         (CW),
                .IDX        (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_kind  (w_kind),
                .i_pos   (w_pos),
                .i_new   (w_store),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[gi]),
                .o_tap   (w_tap[gi])
            );
        end
    endgenerate

    // at most one tap is nonzero after a removal
    always_comb begin
        w_taps_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_taps_or = w_taps_or | w_tap[i];
        end
    end

    assign w_word = w_taps_or;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_status <= w_status;
            r_a_count  <= w_cnt_ext[COUNT_W-1:0];
            r_a_taken  <= (w_kind == SH_REMOVE);
        end
        if (w_a_adv && r_a_valid) begin
            r_out_status  <= r_a_status;
            r_out_count   <= r_a_count;
            r_out_removed <= r_a_taken ? VALUE_W'(w_word) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_removed};

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above DEPTH");

    a_occ_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_put && !w_full) |=> (r_occ == $past(r_occ) + 1'b1))
        else $error("occupancy did not grow on accepted put");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata[31:0] == '0))
        else $error("rejected request returned a word");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_a_adv) |=> (r_a_valid && r_out_valid))
        else $error("stalled result lost");

endmodule

>>> rtl/core/mqi_cell.sv
module mqi_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned PW         = 7,
    parameter int unsigned IDX        = 0
) (
    input  logic                    i_clk,
    input  mqi_pkg::t_shift         i_kind,
    input  logic [PW-1:0]           i_pos,
    input  logic [DATA_WIDTH-1:0]   i_new,
    input  logic [DATA_WIDTH-1:0]   i_left,
    input  logic [DATA_WIDTH-1:0]   i_right,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [DATA_WIDTH-1:0]   o_tap
);
    import mqi_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_tap;
    logic [DATA_WIDTH-1:0] n_tap;
    logic                  w_at;
    logic                  w_behind;

    assign w_at     = (MY_IDX == i_pos);
    assign w_behind = (MY_IDX > i_pos);

    always_comb begin
        n_data = r_data;
        n_tap  = r_tap;
        case (i_kind)
            SH_INSERT: begin
                if (w_at) begin
                    n_data = i_new;
                end else if (w_behind) begin
                    n_data = i_left;
                end
            end
            SH_REMOVE: begin
                // capture the old word at the removal point, zero elsewhere
                n_tap = w_at ? r_data : '0;
                if (w_at || w_behind) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

>>> verif/middle_insert_queue_tb.sv
`timescale 1ns / 100ps

module middle_insert_queue_tb;
    import mqi_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        t_req               kind;
        logic signed [31:0] value;
    } t_req_item;

    typedef struct {
        t_status            status;
        logic signed [31:0] removed;
        logic [6:0]         count;
    } t_queue_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] removed_value, [38:32] count, [39] zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    t_req_item          req_queue[$];
    t_queue_result      awaited_results[$];
    logic signed [31:0] stored_words[$];   // head at index 0

    logic in_taken = 1'b0;
    bit   failed = 1'b0;
    int   idle_cycles = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   mode_left = 0;
    int   stall_left = 0;

    middle_insert_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // applies one request to the shadow store and returns what the block must report
    function automatic t_queue_result apply_request(t_req_item it);
        t_queue_result r;
        int n;
        int pos;
        n = stored_words.size();
        r.status = ST_DONE;
        r.removed = '0;
        case (it.kind)
            REQ_APPEND, REQ_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = (it.kind == REQ_APPEND) ? n : (n + 1) / 2;
                    stored_words.insert(pos, it.value);
                end
            end
            default: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = (it.kind == REQ_DROP) ? 0 : n / 2;
                    r.removed = stored_words[pos];
                    stored_words.delete(pos);
                end
            end
        endcase
        r.count = 7'(stored_words.size());
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic push_req(t_req kind, logic [31:0] value);
        t_req_item it;
        it.kind = kind;
        it.value = value;
        req_queue.push_back(it);
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(negedge i_clk) begin
        t_req_item it;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                it = req_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.value;
                s_axis_tuser <= it.kind;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: always ready, coin flip, or long stalls, switching now and then
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(40, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 1) == 1);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 30);
                    end
                end
            endcase
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        t_req_item it;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                it.kind = t_req'(s_axis_tuser);
                it.value = s_axis_tdata;
                awaited_results.push_back(apply_request(it));
            end
        end
    end

    always @(posedge i_clk) begin
        t_queue_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result transaction: tuser=%0d tdata=%h",
                       m_axis_tuser, m_axis_tdata);
                failed = 1'b1;
            end else begin
                e = awaited_results.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                    failed = 1'b1;
                end
                if (m_axis_tdata[31:0] !== e.removed) begin
                    $error("removed_value: expected %0d, got %0d",
                           e.removed, $signed(m_axis_tdata[31:0]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[38:32] !== e.count) begin
                    $error("count: expected %0d, got %0d", e.count, m_axis_tdata[38:32]);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[middle_insert_queue] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int add_pct;
        // empty store rejections, value extremes, every request kind
        push_req(REQ_DROP, 32'h1111_1111);
        push_req(REQ_REMOVE, 32'h2222_2222);
        push_req(REQ_APPEND, 32'h7fff_ffff);
        push_req(REQ_APPEND, 32'h8000_0000);
        push_req(REQ_INSERT, 32'h0000_0000);
        push_req(REQ_INSERT, 32'hffff_ffff);
        push_req(REQ_INSERT, 32'h5555_5555);
        push_req(REQ_APPEND, 32'haaaa_aaaa);
        push_req(REQ_REMOVE, 32'h0);
        push_req(REQ_REMOVE, 32'h0);
        push_req(REQ_DROP, 32'h0);
        push_req(REQ_INSERT, 32'h0000_0001);
        push_req(REQ_REMOVE, 32'h0);
        push_req(REQ_DROP, 32'h0);
        push_req(REQ_DROP, 32'h0);
        push_req(REQ_REMOVE, 32'h0);
        push_req(REQ_DROP, 32'h0);
        push_req(REQ_INSERT, 32'h1234_5678);
        push_req(REQ_DROP, 32'h0);
        push_req(REQ_DROP, 32'hdead_beef);

        // phases lean toward growth or shrink (every fourth is balanced) so both full and empty are hit often
        for (int s = 0; s < 8; s++) begin
            if (s % 4 == 3) add_pct = 50;
            else if (s % 2 == 0) add_pct = $urandom_range(75, 95);
            else add_pct = $urandom_range(5, 25);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(1, 100) <= add_pct)
                    push_req($urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT, pick_value());
                else
                    push_req($urandom_range(0, 1) ? REQ_DROP : REQ_REMOVE, pick_value());
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (req_queue.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed) begin
            $display("[middle_insert_queue] OK");
        end else begin
            $display("[middle_insert_queue] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mqi_pkg.sv
rtl/core/mqi_cell.sv
rtl/core/middle_insert_queue.sv
verif/middle_insert_queue_tb.sv
